### design/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the checker of the string unescaper.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// No dependencies; every module of the block imports this package.
package jsu_pkg;

  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_QUOTE  = 3'd0,
    ERR_CONTROL   = 3'd1,
    ERR_HEX       = 3'd2,
    ERR_ESCAPE    = 3'd3,
    ERR_EARLY_END = 3'd4
  } err_e;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CTRL_BS    = 8'h08;
  localparam logic [7:0] CTRL_FF    = 8'h0C;
  localparam logic [7:0] CTRL_LF    = 8'h0A;
  localparam logic [7:0] CTRL_CR    = 8'h0D;
  localparam logic [7:0] CTRL_TAB   = 8'h09;

  localparam logic [15:0] CP_MAX1   = 16'h007F;
  localparam logic [15:0] CP_MAX2   = 16'h07FF;
  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  CONT      = 8'h80;

  // One decoded result group handed from the front end to the back end.
  // nbytes is the number of output beats (1 to 3).
  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] code;
    logic [1:0]  nbytes;
  } cmd_t;

endpackage

### design/jsu_if.sv
// Valid/ready channel interfaces of the JSON string unescaper.
// Depends on nothing; used by the top level, the front end and the back end.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

### design/jsu_fifo.sv
// Small register queue of decoded commands between front and back end.
// Depends on jsu_pkg for the command type.
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::cmd_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

### design/jsu_front.sv
// Front end: accepts input bytes, tracks the escape state and classifies
// each byte into a command for the back end. Depends on jsu_pkg, jsu_if.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsu_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] code_q, code_d;
  logic        fire, emit;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] code_next;
  logic [7:0]  c;
  cmd_t        cmd;

  assign c       = in_i.in_byte;
  assign in_i.ready = !full_i;
  assign fire    = in_i.valid && in_i.ready;
  assign push_o  = fire && emit;
  assign cmd_o   = cmd;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = c[3:0];
    case (c) inside
      [8'h30:8'h39]: hex_val = c[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: hex_val = c[3:0] + 4'd9;
      default: hex_ok = 1'b0;
    endcase
  end

  assign code_next = {code_q[11:0], hex_val};

  always_comb begin
    mode_d     = mode_q;
    hex_cnt_d  = hex_cnt_q;
    code_d     = code_q;
    emit       = 1'b0;
    cmd.kind   = KIND_BYTE;
    cmd.err    = ERR_NO_QUOTE;
    cmd.code   = 16'h0000;
    cmd.nbytes = 2'd1;
    if (in_i.end_of_text) begin
      emit      = 1'b1;
      cmd.kind  = KIND_ERR;
      cmd.err   = ERR_EARLY_END;
      mode_d    = MODE_IDLE;
      hex_cnt_d = '0;
      code_d    = '0;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (c == CH_QUOTE) begin
            mode_d = MODE_STR;
          end else begin
            emit      = 1'b1;
            cmd.kind  = KIND_ERR;
            cmd.err   = ERR_NO_QUOTE;
            hex_cnt_d = '0;
            code_d    = '0;
          end
        end
        MODE_STR: begin
          emit = 1'b1;
          if (c == CH_QUOTE) begin
            cmd.kind = KIND_CLOSE;
            mode_d   = MODE_IDLE;
          end else if (c < CH_SPACE) begin
            cmd.kind  = KIND_ERR;
            cmd.err   = ERR_CONTROL;
            mode_d    = MODE_IDLE;
            hex_cnt_d = '0;
            code_d    = '0;
          end else if (c == CH_BSLASH) begin
            emit   = 1'b0;
            mode_d = MODE_ESC;
          end else begin
            cmd.code = {8'h00, c};
          end
        end
        MODE_ESC: begin
          emit   = 1'b1;
          mode_d = MODE_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: cmd.code = {8'h00, c};
            CH_B: cmd.code = {8'h00, CTRL_BS};
            CH_F: cmd.code = {8'h00, CTRL_FF};
            CH_N: cmd.code = {8'h00, CTRL_LF};
            CH_R: cmd.code = {8'h00, CTRL_CR};
            CH_T: cmd.code = {8'h00, CTRL_TAB};
            CH_U: begin
              emit      = 1'b0;
              mode_d    = MODE_HEX;
              hex_cnt_d = '0;
              code_d    = '0;
            end
            default: begin
              cmd.kind  = KIND_ERR;
              cmd.err   = ERR_ESCAPE;
              mode_d    = MODE_IDLE;
              hex_cnt_d = '0;
              code_d    = '0;
            end
          endcase
        end
        default: begin
          if (!hex_ok) begin
            emit      = 1'b1;
            cmd.kind  = KIND_ERR;
            cmd.err   = ERR_HEX;
            mode_d    = MODE_IDLE;
            hex_cnt_d = '0;
            code_d    = '0;
          end else if (hex_cnt_q == 2'd3) begin
            // Fourth digit: the code point is complete and goes out as UTF-8.
            emit      = 1'b1;
            cmd.code  = code_next;
            mode_d    = MODE_STR;
            hex_cnt_d = '0;
            code_d    = code_next;
            if (code_next <= CP_MAX1) begin
              cmd.nbytes = 2'd1;
            end else if (code_next <= CP_MAX2) begin
              cmd.nbytes = 2'd2;
            end else begin
              cmd.nbytes = 2'd3;
            end
          end else begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            code_d    = code_next;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_cnt_q <= '0;
      code_q    <= '0;
    end else if (fire) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      code_q    <= code_d;
    end
  end

endmodule

### design/jsu_back.sv
// Back end: expands queued commands into one to three result beats and
// holds each beat in the output register. Depends on jsu_pkg, jsu_if.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  jsu_pkg::cmd_t head_i,
  output logic          pop_o,
  jsu_out_if.source     out_o
);
  import jsu_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] kind_q;
  logic [2:0] err_q;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load;

  assign load   = head_valid_i && (!valid_q || out_o.ready);
  assign last_d = (idx_q == (head_i.nbytes - 2'd1));
  assign pop_o  = load && last_d;
  assign idx_d  = last_d ? 2'd0 : idx_q + 2'd1;

  // UTF-8 byte for the current beat; single-beat commands carry the byte itself.
  always_comb begin
    case (head_i.nbytes)
      2'd2: begin
        if (idx_q == 2'd0) begin
          byte_d = LEAD2 | {3'b000, head_i.code[10:6]};
        end else begin
          byte_d = CONT | {2'b00, head_i.code[5:0]};
        end
      end
      2'd3: begin
        case (idx_q)
          2'd0:    byte_d = LEAD3 | {4'h0, head_i.code[15:12]};
          2'd1:    byte_d = CONT | {2'b00, head_i.code[11:6]};
          default: byte_d = CONT | {2'b00, head_i.code[5:0]};
        endcase
      end
      default: byte_d = head_i.code[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      kind_q <= head_i.kind;
      err_q  <= head_i.err;
      last_q <= last_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.kind       = kind_q;
  assign out_o.error_code = err_q;
  assign out_o.last       = last_q;

endmodule

### design/json_string_unescape_utf8.sv
// JSON string literal unescaper with UTF-8 output.
// Input channel in_i: one beat per text byte, starting at the opening quote;
// end_of_text marks a beat that carries no byte and ends the text early.
// Output channel out_o: one beat per result. kind gives a decoded byte, the
// closing of the string or an error with its error_code; last marks the
// final beat caused by one input beat. Escapes and hex digits that finish
// nothing give no beat; a completed \u escape gives one to three beats.
// An accepted input beat is written into the command queue and, once at its
// head, loaded into the output register. Input runs at one beat per cycle
// while the queue is not full; the output register sends one beat per cycle
// while out_o.ready is high; a \u escape to three bytes takes three beats.
// The command queue (QueueDepth entries) decouples the two sides: in_i.ready
// drops only when the queue is full, and a stalled out_o holds its beat
// stable until taken. Reset clears the decode state to idle, empties the
// queue and drops out_o.valid; the block is ready right after reset.
// Depends on jsu_pkg, jsu_if, jsu_fifo, jsu_front and jsu_back.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

### design/jsu_checker.sv
// Port-level checks on the result channel of the JSON string unescaper.
// Depends on jsu_pkg and json_string_unescape_utf8_macros.svh; bound below.
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] kind_i,
  input logic [2:0] error_code_i,
  input logic       last_i
);
  import jsu_pkg::*;

  // A stalled beat must hold; the back end may only reload on a taken beat.
  `JSU_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(kind_i) && $stable(error_code_i) && $stable(last_i), "stalled beat changed")

  // A closing quote is a lone, empty, error-free beat.
  `JSU_ASSERT_NOW(a_close, out_valid_i && (kind_i == KIND_CLOSE), last_i && (out_byte_i == 8'h00) && (error_code_i == ERR_NO_QUOTE), "malformed close beat")

  // An error is a lone beat with no data byte.
  `JSU_ASSERT_NOW(a_error, out_valid_i && (kind_i == KIND_ERR), last_i && (out_byte_i == 8'h00), "malformed error beat")

  // Data beats never carry an error code.
  `JSU_ASSERT_NOW(a_data, out_valid_i && (kind_i == KIND_BYTE), error_code_i == ERR_NO_QUOTE, "data beat with error code")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .kind_i       (out_o.kind),
  .error_code_i (out_o.error_code),
  .last_i       (out_o.last)
);

### tb/jsu_unescape_checker.sv
// Checker for the JSON string unescaper: watches both channels, decodes every
// accepted text byte on its own and compares each output beat in order.
// Depends on jsu_pkg and the channel interfaces in jsu_if.
module jsu_unescape_checker (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  output int   mismatch_count,
  output int   awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
    logic       last;
  } beat_t;

  mode_e       mode_q;
  logic [1:0]  digits_q;
  logic [15:0] code_q;
  beat_t       awaited_beats[$];
  int          failures;

  function automatic beat_t make_beat(input logic [7:0] data, input kind_e kind,
                                      input err_e err);
    beat_t bt;
    bt.data = data;
    bt.kind = kind;
    bt.err  = err;
    bt.last = 1'b0;
    return bt;
  endfunction

  // Advances the decoder by one text byte and queues the beats it produces.
  function automatic void decode_text_byte(input logic [7:0] ch, input logic eot);
    beat_t       step_q[$];
    logic [3:0]  nib;
    logic [15:0] cp;
    logic [7:0]  lit;
    logic        failed;
    err_e        cause;
    nib    = 4'd0;
    lit    = ch;
    failed = 1'b0;
    cause  = ERR_NO_QUOTE;
    if (eot) begin
      failed = 1'b1;
      cause  = ERR_EARLY_END;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (ch == CH_QUOTE) begin
            mode_q = MODE_STR;
          end else begin
            failed = 1'b1;
            cause  = ERR_NO_QUOTE;
          end
        end
        MODE_STR: begin
          if (ch == CH_QUOTE) begin
            mode_q = MODE_IDLE;
            step_q = {step_q, make_beat(8'h00, KIND_CLOSE, ERR_NO_QUOTE)};
          end else if (ch < CH_SPACE) begin
            failed = 1'b1;
            cause  = ERR_CONTROL;
          end else if (ch == CH_BSLASH) begin
            mode_q = MODE_ESC;
          end else begin
            step_q = {step_q, make_beat(ch, KIND_BYTE, ERR_NO_QUOTE)};
          end
        end
        MODE_ESC: begin
          case (ch)
            CH_QUOTE, CH_BSLASH, CH_SLASH: lit = ch;
            CH_B: lit = CTRL_BS;
            CH_F: lit = CTRL_FF;
            CH_N: lit = CTRL_LF;
            CH_R: lit = CTRL_CR;
            CH_T: lit = CTRL_TAB;
            CH_U: begin
              mode_q   = MODE_HEX;
              digits_q = 2'd0;
              code_q   = 16'h0000;
            end
            default: begin
              failed = 1'b1;
              cause  = ERR_ESCAPE;
            end
          endcase
          if (!failed && ch != CH_U) begin
            mode_q = MODE_STR;
            step_q = {step_q, make_beat(lit, KIND_BYTE, ERR_NO_QUOTE)};
          end
        end
        default: begin
          if (ch inside {["0":"9"]}) begin
            nib = 4'(ch - 8'("0"));
          end else if (ch inside {["a":"f"]}) begin
            nib = 4'(ch - 8'("a") + 8'd10);
          end else if (ch inside {["A":"F"]}) begin
            nib = 4'(ch - 8'("A") + 8'd10);
          end else begin
            failed = 1'b1;
            cause  = ERR_HEX;
          end
          if (!failed) begin
            code_q = {code_q[11:0], nib};
            if (digits_q == 2'd3) begin
              mode_q   = MODE_STR;
              digits_q = 2'd0;
              cp       = code_q;
              if (cp <= CP_MAX1) begin
                step_q = {step_q, make_beat(cp[7:0], KIND_BYTE, ERR_NO_QUOTE)};
              end else if (cp <= CP_MAX2) begin
                step_q = {step_q,
                          make_beat(LEAD2 | {3'b0, cp[10:6]}, KIND_BYTE, ERR_NO_QUOTE)};
                step_q = {step_q,
                          make_beat(CONT | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NO_QUOTE)};
              end else begin
                step_q = {step_q,
                          make_beat(LEAD3 | {4'b0, cp[15:12]}, KIND_BYTE, ERR_NO_QUOTE)};
                step_q = {step_q,
                          make_beat(CONT | {2'b0, cp[11:6]}, KIND_BYTE, ERR_NO_QUOTE)};
                step_q = {step_q,
                          make_beat(CONT | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NO_QUOTE)};
              end
            end else begin
              digits_q = digits_q + 2'd1;
            end
          end
        end
      endcase
    end
    if (failed) begin
      mode_q   = MODE_IDLE;
      digits_q = 2'd0;
      code_q   = 16'h0000;
      step_q   = {step_q, make_beat(8'h00, KIND_ERR, cause)};
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    awaited_beats = {awaited_beats, step_q};
  endfunction

  always @(posedge clk_i) begin
    beat_t want;
    if (!rst_ni) begin
      mode_q   = MODE_IDLE;
      digits_q = 2'd0;
      code_q   = 16'h0000;
      failures = 0;
      awaited_beats.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_text_byte(in_mon.in_byte, in_mon.end_of_text);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_beats.size() == 0) begin
          failures++;
          $error("unexpected beat: out_byte %02h kind %0d error_code %0d last %0b",
                 out_mon.out_byte, out_mon.kind, out_mon.error_code, out_mon.last);
        end else begin
          want = awaited_beats.pop_front();
          if (out_mon.out_byte !== want.data) begin
            failures++;
            $error("out_byte mismatch: expected %02h, got %02h", want.data, out_mon.out_byte);
          end
          if (out_mon.kind !== want.kind) begin
            failures++;
            $error("kind mismatch: expected %0d, got %0d", want.kind, out_mon.kind);
          end
          if (out_mon.error_code !== want.err) begin
            failures++;
            $error("error_code mismatch: expected %0d, got %0d", want.err,
                   out_mon.error_code);
          end
          if (out_mon.last !== want.last) begin
            failures++;
            $error("last mismatch: expected %0b, got %0b", want.last, out_mon.last);
          end
        end
      end
    end
    mismatch_count <= failures;
    awaited_count  <= awaited_beats.size();
  end

endmodule

### tb/tb_json_string_unescape_utf8.sv
// Top of the JSON string unescaper testbench: clock, reset, text stimulus and
// output back-pressure; the verdict comes from the failure and awaited counts of the checker.
// Depends on jsu_pkg, jsu_if, the block itself and jsu_unescape_checker.
module tb_json_string_unescape_utf8;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 80;
  localparam logic [7:0] EscLetters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                            CH_F, CH_N, CH_R, CH_T};

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic hold_off    = 1'b0;
  logic start_hold  = 1'b0;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   mismatch_count;
  int   awaited_count;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_utf8 i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  jsu_unescape_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_if.ready <= 1'b0;
    else out_if.ready <= (int'($urandom_range(99)) >= sink_idle_pct);
  end

  // One long stall of the output while text keeps coming, so the queue fills.
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Valid stays high from one beat to the next unless an idle cycle is drawn.
  task automatic send_beat(input logic [7:0] ch, input logic eot);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= ch;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s.getc(i), 1'b0);
  endtask

  // Backslash, u and the leading ndigits hex digits of cp in mixed case.
  task automatic send_u_escape(input logic [15:0] cp, input int ndigits);
    logic [3:0] nib;
    logic [7:0] ch;
    send_beat(CH_BSLASH, 1'b0);
    send_beat(CH_U, 1'b0);
    for (int i = 0; i < ndigits; i++) begin
      nib = cp[15 - 4 * i -: 4];
      if (nib < 4'd10) ch = 8'("0") + 8'(nib);
      else if ($urandom_range(1) == 1) ch = 8'("A") + 8'(nib) - 8'd10;
      else ch = 8'("a") + 8'(nib) - 8'd10;
      send_beat(ch, 1'b0);
    end
  endtask

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(16'h007F));
      1:       return 16'($urandom_range(16'h07FF, 16'h0080));
      2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
      3:       return 16'($urandom_range(16'hDFFF, 16'hD800));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0] ch;
    int         pick;
    if ($urandom_range(9) == 0) begin
      do ch = 8'($urandom); while (ch == CH_QUOTE);
      send_beat(ch, 1'b0);
    end
    send_beat(CH_QUOTE, 1'b0);
    repeat ($urandom_range(10)) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        do ch = 8'($urandom_range(8'hFF, 8'h20)); while (ch == CH_QUOTE || ch == CH_BSLASH);
        send_beat(ch, 1'b0);
      end else if (pick < 7) begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(EscLetters[$urandom_range(7)], 1'b0);
      end else begin
        send_u_escape(pick_code_point(), 4);
      end
    end
    pick = $urandom_range(19);
    if (pick < 13) begin
      send_beat(CH_QUOTE, 1'b0);
    end else if (pick == 13) begin
      send_beat(8'($urandom_range(8'h1F)), 1'b0);
    end else if (pick == 14) begin
      send_beat(CH_BSLASH, 1'b0);
      do ch = 8'($urandom);
      while (ch inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      send_beat(ch, 1'b0);
    end else if (pick == 15) begin
      send_u_escape(pick_code_point(), $urandom_range(3));
      if ($urandom_range(1) == 1) ch = CH_QUOTE;
      else do ch = 8'($urandom); while (ch inside {["0":"9"], ["a":"f"], ["A":"F"]});
      send_beat(ch, 1'b0);
    end else if (pick == 16) begin
      send_beat(8'($urandom), 1'b1);
    end else if (pick == 17) begin
      send_beat(CH_BSLASH, 1'b0);
      send_beat(8'($urandom), 1'b1);
    end else if (pick == 18) begin
      send_u_escape(pick_code_point(), $urandom_range(3));
      send_beat(8'($urandom), 1'b1);
    end else begin
      // Closed string followed by stray bytes before the next opening quote.
      send_beat(CH_QUOTE, 1'b0);
      repeat ($urandom_range(2, 1)) begin
        do ch = 8'($urandom); while (ch == CH_QUOTE);
        send_beat(ch, 1'b0);
      end
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.in_byte     = 8'h00;
    in_if.end_of_text = 1'b0;
    out_if.ready      = 1'b0;
    src_idle_pct      = 22;
    sink_idle_pct     = 82;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_SPACE, 1'b0);
    send_chars("\\u0000\\uFfFf\\n\"");
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'h1F, 1'b0);
    send_chars("\"\\x");

    while (items_sent < 150) send_random_string();
    src_idle_pct  = 82;
    sink_idle_pct = 22;
    while (items_sent < 300) send_random_string();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    start_hold    = 1'b1;
    while (items_sent < 450) send_random_string();
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_fifo.sv
design/jsu_front.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
design/jsu_checker.sv
tb/jsu_unescape_checker.sv
tb/tb_json_string_unescape_utf8.sv
